/* hw/rtl/sfdf_pkg.sv */
// Package for the sensor frame decimal formatter.
// Holds widths, ASCII codes, controller state and command/status types.
// No dependencies.
package sfdf_pkg;

    localparam int FIELD_COUNT    = 6;
    localparam int NUM_VALUES_DEF = 6;
    localparam int VAL_W          = 16;
    localparam int CHAR_W         = 8;
    localparam int DIGITS         = 5;
    localparam int BCD_W          = 4 * DIGITS;
    localparam int CNT_W          = $clog2(VAL_W + 1);
    localparam int DIG_W          = $clog2(DIGITS);
    localparam int IDX_W          = $clog2(FIELD_COUNT);
    localparam int IN_W           = FIELD_COUNT * VAL_W;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] ASCII_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] ASCII_CR    = 8'h0D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SIGN,
        ST_CONV,
        ST_DIGIT,
        ST_SEP,
        ST_NL,
        ST_CR
    } t_state;

    typedef enum logic [2:0] {
        CH_MINUS,
        CH_DIGIT,
        CH_SEMI,
        CH_LF,
        CH_CR
    } t_char_sel;

    typedef struct packed {
        logic      load;
        logic      start;
        logic      step;
        logic      dig_init;
        logic      dig_dec;
        logic      next_val;
        logic      emit;
        t_char_sel sel;
        logic      last;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic conv_done;
        logic dig_zero;
        logic last_val;
        logic out_free;
    } t_stat;

endpackage

/* hw/rtl/sfdf_ctrl.sv */
// Controller state machine of the sensor frame decimal formatter.
// Sequences sign, conversion, digits and separators; uses sfdf_pkg.
module sfdf_ctrl import sfdf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_START;
            end
            ST_START: begin
                n_state = i_stat.neg ? ST_SIGN : ST_CONV;
            end
            ST_SIGN: begin
                if (i_stat.out_free) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (i_stat.conv_done) n_state = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (i_stat.out_free && i_stat.dig_zero) begin
                    n_state = i_stat.last_val ? ST_NL : ST_SEP;
                end
            end
            ST_SEP: begin
                if (i_stat.out_free) n_state = ST_START;
            end
            ST_NL: begin
                if (i_stat.out_free) n_state = ST_CR;
            end
            ST_CR: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.sel  = CH_DIGIT;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_START: begin
                o_cmd.start = 1'b1;
            end
            ST_SIGN: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.sel  = CH_MINUS;
            end
            ST_CONV: begin
                o_cmd.step     = !i_stat.conv_done;
                o_cmd.dig_init = i_stat.conv_done;
            end
            ST_DIGIT: begin
                o_cmd.emit    = i_stat.out_free;
                o_cmd.sel     = CH_DIGIT;
                o_cmd.dig_dec = i_stat.out_free;
            end
            ST_SEP: begin
                o_cmd.emit     = i_stat.out_free;
                o_cmd.sel      = CH_SEMI;
                o_cmd.next_val = i_stat.out_free;
            end
            ST_NL: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.sel  = CH_LF;
            end
            ST_CR: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.sel  = CH_CR;
                o_cmd.last = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/sfdf_datapath.sv */
// Datapath of the sensor frame decimal formatter: frame register, magnitude,
// shift-add-3 binary to BCD converter, digit pointer and output register.
// Uses sfdf_pkg; driven by sfdf_ctrl.
module sfdf_datapath import sfdf_pkg::*; #(
    parameter int NUM_VALUES = NUM_VALUES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IN_W-1:0]   i_frame,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_out_last
);

    localparam int COUNT = (NUM_VALUES > FIELD_COUNT) ? FIELD_COUNT :
                           (NUM_VALUES < 1) ? 1 : NUM_VALUES;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COUNT - 1);

    logic [VAL_W-1:0]  r_vals [FIELD_COUNT];
    logic [IDX_W-1:0]  r_idx;
    logic [VAL_W-1:0]  r_mag;
    logic [BCD_W-1:0]  r_bcd;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIG_W-1:0]  r_dig;
    logic              r_ovalid;
    logic [CHAR_W-1:0] r_ochar;
    logic              r_olast;

    logic [VAL_W-1:0]  cur_val;
    logic [BCD_W-1:0]  bcd_adj;
    logic [DIG_W-1:0]  lead;
    logic [3:0]        cur_digit;
    logic [CHAR_W-1:0] char_mux;

    assign cur_val = r_vals[r_idx];

    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ?
                                r_bcd[4*d +: 4] + 4'd3 : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        lead = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) lead = DIG_W'(d);
        end
    end

    assign cur_digit = r_bcd[4*r_dig +: 4];

    always_comb begin
        case (i_cmd.sel)
            CH_MINUS: char_mux = ASCII_MINUS;
            CH_DIGIT: char_mux = ASCII_ZERO + {4'd0, cur_digit};
            CH_SEMI:  char_mux = ASCII_SEMI;
            CH_LF:    char_mux = ASCII_LF;
            CH_CR:    char_mux = ASCII_CR;
            default:  char_mux = ASCII_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int f = 0; f < FIELD_COUNT; f++) begin
                r_vals[f] <= i_frame[f*VAL_W +: VAL_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.next_val) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.start) begin
                r_cnt <= '0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mag <= cur_val[VAL_W-1] ? (~cur_val + 1'b1) : cur_val;
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            {r_bcd, r_mag} <= {bcd_adj[BCD_W-2:0], r_mag, 1'b0};
        end
        if (i_cmd.dig_init) begin
            r_dig <= lead;
        end else if (i_cmd.dig_dec) begin
            r_dig <= r_dig - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ochar <= char_mux;
            r_olast <= i_cmd.last;
        end
    end

    // sign of the value being started, valid in the start cycle
    assign o_stat.neg       = cur_val[VAL_W-1];
    assign o_stat.conv_done = (r_cnt == CNT_W'(VAL_W));
    assign o_stat.dig_zero  = (r_dig == '0);
    assign o_stat.last_val  = (r_idx == LAST_IDX);
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_char  = r_ochar;
    assign o_out_last  = r_olast;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(VAL_W))
        else $error("conversion counter past end");

    a_digit_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.sel == CH_DIGIT) |-> o_stat.conv_done)
        else $error("digit sent before conversion finished");

    a_digit_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.sel == CH_DIGIT) |-> cur_digit <= 4'd9)
        else $error("digit out of BCD range");

    a_last_is_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> r_ochar == ASCII_CR)
        else $error("frame end not on carriage return");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ovalid || i_out_ready))
        else $error("output register overwritten");

endmodule

/* hw/rtl/sensor_frame_decimal_formatter_unit.sv */
// Top level of the sensor frame decimal formatter.
// Instantiates sfdf_ctrl and sfdf_datapath; uses sfdf_pkg.
//
// One input transfer carries a frame of six signed 16-bit samples; the block
// answers with one character transfer per ASCII byte: each value in decimal
// (leading '-' if negative, no leading zeros), ';' between values, then
// newline and carriage return, the carriage return flagged by tlast. Frames
// are handled one at a time. Each frame begins with a load; each value then
// passes through a start state, a minus sign if negative, the 16-step
// shift-add-3 BCD converter, its digits and the separator. The next frame is
// taken as soon as the carriage return is in the output register.
module sensor_frame_decimal_formatter_unit import sfdf_pkg::*; #(
    parameter int NUM_VALUES = NUM_VALUES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // character
    output logic [CHAR_W-1:0] o_m_axis_tdata,
    output logic              o_m_axis_tlast
);

    t_cmd  cmd;
    t_stat stat;

    sfdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sfdf_datapath #(
        .NUM_VALUES (NUM_VALUES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_char  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule
